// ===== design/pwt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the point weld table.
// Used by pwt_cell, point_weld_table_unit and pwt_checker.
package pwt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COORD_W     = 32;
  localparam int BOUND_W     = COORD_W + 1;
  localparam int TOL_W       = 20;
  localparam int NODE_ID_W   = 7;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10);

  // Query traveling down the cell chain, one cell per cycle while the chain advances.
  typedef struct packed {
    logic                       valid;
    logic                       found;
    logic                       is_new;
    logic [NODE_ID_W-1:0]       node_id;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic signed [BOUND_W-1:0]  x_lo;
    logic signed [BOUND_W-1:0]  x_hi;
    logic signed [BOUND_W-1:0]  y_lo;
    logic signed [BOUND_W-1:0]  y_hi;
    logic signed [BOUND_W-1:0]  z_lo;
    logic signed [BOUND_W-1:0]  z_hi;
  } query_t;

endpackage

// ===== design/pwt_cell.sv =====
`timescale 1ns / 1ps
// One table entry of the weld chain: holds a stored point and its used bit,
// compares the passing query against it and claims the query on hit or fill.
// Depends on pwt_pkg.
module pwt_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [pwt_pkg::NODE_ID_W-1:0]     cell_id,
  input  pwt_pkg::query_t                   query_in,
  output pwt_pkg::query_t                   query_out
);
  import pwt_pkg::*;

  logic                      used;
  logic signed [COORD_W-1:0] sx;
  logic signed [COORD_W-1:0] sy;
  logic signed [COORD_W-1:0] sz;

  logic signed [BOUND_W-1:0] sx_ext;
  logic signed [BOUND_W-1:0] sy_ext;
  logic signed [BOUND_W-1:0] sz_ext;
  logic                      hit;
  logic                      open;

  assign sx_ext = BOUND_W'(sx);
  assign sy_ext = BOUND_W'(sy);
  assign sz_ext = BOUND_W'(sz);

  // Stored point lies strictly inside the query's box on every axis.
  assign hit = used &&
               (sx_ext > query_in.x_lo) && (sx_ext < query_in.x_hi) &&
               (sy_ext > query_in.y_lo) && (sy_ext < query_in.y_hi) &&
               (sz_ext > query_in.z_lo) && (sz_ext < query_in.z_hi);

  assign open = query_in.valid && !query_in.found;

  always_ff @(posedge clk) begin
    if (rst) begin
      used            <= 1'b0;
      query_out.valid <= 1'b0;
    end else if (advance) begin
      query_out <= query_in;
      if (open && hit) begin
        query_out.found   <= 1'b1;
        query_out.node_id <= cell_id;
      end else if (open && !used) begin
        // First free entry: append the point here.
        query_out.found   <= 1'b1;
        query_out.is_new  <= 1'b1;
        query_out.node_id <= cell_id;
        used              <= 1'b1;
        sx                <= query_in.x;
        sy                <= query_in.y;
        sz                <= query_in.z;
      end
    end
  end

endmodule

// ===== design/point_weld_table_unit.sv =====
`timescale 1ns / 1ps
// Point weld table: a chain of TABLE_DEPTH entry cells, one query step per cycle.
// A query is registered first in the bound register and then in each cell in turn,
// and the last cell's register drives the result outputs.
// Throughput: one point per cycle unless a valid result is held by out_stall, which freezes the whole chain.
// Synchronous reset empties the table and sets the tolerance to 10.
module point_weld_table_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pwt_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [pwt_pkg::COORD_W-1:0]  y_coord,
  input  logic signed [pwt_pkg::COORD_W-1:0]  z_coord,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pwt_pkg::NODE_ID_W-1:0]       node_id,
  output logic                                is_new,
  output logic                                table_full,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwt_pkg::TOL_W-1:0]           cfg_data
);
  import pwt_pkg::*;

  logic [TOL_W-1:0]          match_tolerance;
  logic                      advance;
  logic signed [BOUND_W-1:0] tol_ext;
  query_t                    chain [TABLE_DEPTH+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      match_tolerance <= cfg_data;
    end
  end

  // Hold everything while the result register is stalled.
  assign advance  = !(chain[TABLE_DEPTH].valid && out_stall);
  assign in_stall = !advance;

  assign tol_ext = $signed({{(BOUND_W-TOL_W){1'b0}}, match_tolerance});

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (advance) begin
      chain[0].valid   <= in_valid;
      chain[0].found   <= 1'b0;
      chain[0].is_new  <= 1'b0;
      chain[0].node_id <= '0;
      chain[0].x       <= x_coord;
      chain[0].y       <= y_coord;
      chain[0].z       <= z_coord;
      chain[0].x_lo    <= BOUND_W'(x_coord) - tol_ext;
      chain[0].x_hi    <= BOUND_W'(x_coord) + tol_ext;
      chain[0].y_lo    <= BOUND_W'(y_coord) - tol_ext;
      chain[0].y_hi    <= BOUND_W'(y_coord) + tol_ext;
      chain[0].z_lo    <= BOUND_W'(z_coord) - tol_ext;
      chain[0].z_hi    <= BOUND_W'(z_coord) + tol_ext;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pwt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .cell_id   (NODE_ID_W'(i + 1)),
      .query_in  (chain[i]),
      .query_out (chain[i+1])
    );
  end

  // A query that leaves the chain unclaimed found neither a match nor room.
  assign out_valid  = chain[TABLE_DEPTH].valid;
  assign node_id    = chain[TABLE_DEPTH].node_id;
  assign is_new     = chain[TABLE_DEPTH].is_new;
  assign table_full = !chain[TABLE_DEPTH].found;

endmodule

// ===== design/pwt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for point_weld_table_unit, attached by bind.
// Depends on pwt_pkg.
module pwt_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_stall,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [pwt_pkg::NODE_ID_W-1:0]       node_id,
  input  logic                                is_new,
  input  logic                                table_full
);
  import pwt_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_id) && $stable(is_new) &&
                               $stable(table_full))
    else $error("stalled result changed");

  // Input backpressure comes only from a stalled result.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall without stalled result");

  a_full_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> node_id == '0 && !is_new)
    else $error("full result carries an identifier");

  a_hit_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !table_full |-> node_id != '0)
    else $error("matched or inserted result has identifier zero");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind point_weld_table_unit pwt_checker u_pwt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .node_id    (node_id),
  .is_new     (is_new),
  .table_full (table_full)
);
